FILE: hw/rtl/garev_pkg.sv
// Shared types, widths and constants for the gated attack/release envelope VCA.
`timescale 1ns / 1ps
`default_nettype none
package garev_pkg;
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 23;
    localparam int LEVEL_W     = FRAC_BITS + 1;
    localparam int COEF_W      = 24;
    localparam int GAIN_W      = 24;
    localparam int EVENT_W     = 2;
    localparam int CLAMP_W     = (COEF_W > LEVEL_W) ? COEF_W : LEVEL_W;
    localparam int S_DATA_W    = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_RAW_W     = 2 * SAMPLE_BITS + GAIN_W;
    localparam int M_DATA_W    = ((M_RAW_W + 7) / 8) * 8;
    localparam int APB_DATA_W  = 32;
    localparam int PADDR_W     = 3;

    localparam logic [LEVEL_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [COEF_W-1:0]  ATTACK_COEF_RESET  = 24'd67109;
    localparam logic [COEF_W-1:0]  RELEASE_COEF_RESET = 24'd2486;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE   = 2'd0,
        EV_ON     = 2'd1,
        EV_OFF    = 2'd2,
        EV_UNUSED = 2'd3
    } t_event;

    typedef enum logic {
        REG_ATTACK  = 1'b0,
        REG_RELEASE = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GAIN,
        ST_SCALE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic step;
        logic scale;
        logic load_out;
    } t_ctrl;
endpackage
`default_nettype wire

FILE: hw/rtl/garev_smooth.sv
// One-pole smoother lane: level moves toward its goal by a clamped coefficient.
`timescale 1ns / 1ps
`default_nettype none
module garev_smooth (
    input  logic [garev_pkg::LEVEL_W-1:0] i_level,
    input  logic                          i_goal,
    input  logic [garev_pkg::COEF_W-1:0]  i_coef,
    output logic [garev_pkg::LEVEL_W-1:0] o_level
);
    import garev_pkg::*;

    logic        [LEVEL_W-1:0]   coef_q;
    logic signed [LEVEL_W:0]     diff;
    logic signed [2*LEVEL_W+1:0] prod;
    logic signed [2*LEVEL_W+1:0] shifted;
    logic signed [LEVEL_W:0]     delta;
    logic        [LEVEL_W:0]     sum;

    always_comb begin
        if (CLAMP_W'(i_coef) > CLAMP_W'(ONE_Q)) begin
            coef_q = ONE_Q;
        end else begin
            coef_q = LEVEL_W'(i_coef);
        end
        diff    = $signed({1'b0, (i_goal ? ONE_Q : {LEVEL_W{1'b0}})})
                - $signed({1'b0, i_level});
        prod    = diff * $signed({1'b0, coef_q});
        shifted = prod >>> FRAC_BITS;
        delta   = shifted[LEVEL_W:0];
        sum     = {1'b0, i_level} + delta;
        o_level = sum[LEVEL_W-1:0];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/garev_scale.sv
// Sample lane: registered product of one sample and the gain, floor shifted.
`timescale 1ns / 1ps
`default_nettype none
module garev_scale (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [garev_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic        [garev_pkg::LEVEL_W-1:0]     i_gain,
    output logic signed [garev_pkg::SAMPLE_BITS-1:0] o_result
);
    import garev_pkg::*;

    logic signed [SAMPLE_BITS+LEVEL_W:0] prod;
    logic signed [SAMPLE_BITS+LEVEL_W:0] shifted;
    logic signed [SAMPLE_BITS-1:0]       r_result;
    logic signed [SAMPLE_BITS-1:0]       n_result;

    always_comb begin
        prod     = i_sample * $signed({1'b0, i_gain});
        shifted  = prod >>> FRAC_BITS;
        n_result = shifted[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;
endmodule
`default_nettype wire

FILE: hw/rtl/gated_attack_release_envelope_vca.sv
// Top level: gate decode, envelope lanes, sample lanes and output merge register.
//
//  channel   dir  beat contents
//  s_axis    in   tuser: gate_event; tdata: left_in, right_in
//  m_axis    out  tdata: left_out, right_out, gain
//  apb       in   attack_coef at 0x0, release_coef at 0x4
//
// A beat passes through accept, gain and level update, sample multiply and output load, in that order.
// The sequencer holds one frame at a time; the output register frees the input side.
// A stalled m_axis holds the frame in the output-load step.
// Synchronous active-low reset restores levels, goals and coefficients.
`timescale 1ns / 1ps
`default_nettype none
module gated_attack_release_envelope_vca (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [47:0] left_in, right_in
    input  logic [garev_pkg::S_DATA_W-1:0]      s_axis_tdata,
    // [1:0] gate_event
    input  logic [garev_pkg::EVENT_W-1:0]       s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [71:0] left_out, right_out, gain
    output logic [garev_pkg::M_DATA_W-1:0]      m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [garev_pkg::PADDR_W-1:0]       paddr,
    input  logic [garev_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [garev_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import garev_pkg::*;

    t_state r_state, n_state;
    t_ctrl  ctrl;

    logic [COEF_W-1:0]  r_attack_coef, r_release_coef;
    logic [LEVEL_W-1:0] r_att_level, r_rel_level;
    logic               r_att_goal, r_rel_goal;
    logic [LEVEL_W-1:0] n_att_level, n_rel_level;
    logic [LEVEL_W-1:0] att_step, rel_step;
    logic [LEVEL_W-1:0] r_gain;
    logic [2*LEVEL_W-1:0] gain_prod;
    logic signed [SAMPLE_BITS-1:0] r_left, r_right;
    logic signed [SAMPLE_BITS-1:0] left_res, right_res;
    logic signed [SAMPLE_BITS-1:0] r_left_out, r_right_out;
    logic [LEVEL_W-1:0] r_gain_out;
    logic               r_out_valid;
    logic               s_acc;
    logic               cfg_wr;
    t_event             ev;
    t_reg_idx           reg_idx;

    assign s_acc   = s_axis_tvalid && s_axis_tready;
    assign ev      = t_event'(s_axis_tuser);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_coef  <= ATTACK_COEF_RESET;
            r_release_coef <= RELEASE_COEF_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_ATTACK:  r_attack_coef  <= pwdata[COEF_W-1:0];
                REG_RELEASE: r_release_coef <= pwdata[COEF_W-1:0];
                default:     r_attack_coef  <= r_attack_coef;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ATTACK:  prdata = APB_DATA_W'(r_attack_coef);
            REG_RELEASE: prdata = APB_DATA_W'(r_release_coef);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        ctrl          = '0;
        s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = ST_GAIN;
                end
            end
            ST_GAIN: begin
                ctrl.step = 1'b1;
                n_state   = ST_SCALE;
            end
            ST_SCALE: begin
                ctrl.scale = 1'b1;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    ctrl.load_out = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    garev_smooth u_att_lane (
        .i_level (r_att_level),
        .i_goal  (r_att_goal),
        .i_coef  (r_attack_coef),
        .o_level (att_step)
    );

    garev_smooth u_rel_lane (
        .i_level (r_rel_level),
        .i_goal  (r_rel_goal),
        .i_coef  (r_release_coef),
        .o_level (rel_step)
    );

    assign gain_prod = r_att_level * r_rel_level;

    always_comb begin
        n_att_level = r_att_level;
        n_rel_level = r_rel_level;
        if (s_acc) begin
            unique case (ev)
                EV_ON: begin
                    n_att_level = '0;
                    n_rel_level = ONE_Q;
                end
                EV_OFF:  n_rel_level = ONE_Q;
                default: n_rel_level = r_rel_level;
            endcase
        end else if (ctrl.step) begin
            n_att_level = att_step;
            n_rel_level = rel_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_att_level <= '0;
            r_att_goal  <= 1'b0;
            r_rel_level <= ONE_Q;
            r_rel_goal  <= 1'b1;
        end else begin
            r_att_level <= n_att_level;
            r_rel_level <= n_rel_level;
            if (s_acc && ev == EV_ON) begin
                r_att_goal <= 1'b1;
                r_rel_goal <= 1'b1;
            end else if (s_acc && ev == EV_OFF) begin
                r_rel_goal <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_left  <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_right <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
        if (ctrl.step) begin
            r_gain <= gain_prod[FRAC_BITS +: LEVEL_W];
        end
    end

    garev_scale u_left_lane (
        .i_clk    (i_clk),
        .i_en     (ctrl.scale),
        .i_sample (r_left),
        .i_gain   (r_gain),
        .o_result (left_res)
    );

    garev_scale u_right_lane (
        .i_clk    (i_clk),
        .i_en     (ctrl.scale),
        .i_sample (r_right),
        .i_gain   (r_gain),
        .o_result (right_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.load_out) begin
            r_left_out  <= left_res;
            r_right_out <= right_res;
            r_gain_out  <= r_gain;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_DATA_W'({GAIN_W'(r_gain_out), r_right_out, r_left_out});

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_gain_out <= ONE_Q))
        else $error("gain above one");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_att_level <= ONE_Q) && (r_rel_level <= ONE_Q))
        else $error("envelope level above one");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_OUT))
        else $error("output loaded outside output step");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GAIN) |=> (r_state == ST_SCALE) && !s_axis_tready)
        else $error("sequencer skipped sample multiply");
endmodule
`default_nettype wire
